// ===== design/kbht_pkg.sv =====
package kbht_pkg;

  localparam int unsigned SlotsDefault = 64;

  // stored entry layout: valid, percussion, msb, lsb
  localparam int unsigned EntryW = 16;
  localparam int unsigned KeyW   = 15;
  localparam int unsigned HashW  = 15;

  localparam logic [6:0] PercMsb = 7'd127;

  typedef struct packed {
    logic       opcode;
    logic [6:0] bank_msb;
    logic [6:0] bank_lsb;
    logic       percussion;
  } in_word_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] slot_index;
    logic       inserted;
    logic       table_full;
    logic [6:0] entry_count;
  } out_word_t;

  localparam logic OpLookup = 1'b0;
  localparam logic OpInsert = 1'b1;

endpackage

// ===== design/kbht_mem.sv =====
module kbht_mem #(
  parameter int unsigned Depth = kbht_pkg::SlotsDefault,
  parameter int unsigned Width = kbht_pkg::EntryW,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/kbht_hash.sv =====
module kbht_hash #(
  parameter int unsigned Slots = kbht_pkg::SlotsDefault,
  localparam int unsigned AddrW = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kbht_pkg::KeyW-1:0] key_i,
  output logic                      done_o,
  output logic [AddrW-1:0]          slot_o
);

  localparam int unsigned HashW  = kbht_pkg::HashW;
  localparam bit          IsPow2 = ((Slots & (Slots - 1)) == 0);

  // raw hash: percussion*256 + msb*128 + lsb
  logic [HashW-1:0] hash;
  assign hash = {6'd0, key_i[14], 8'd0} + {1'b0, key_i[13:7], 7'd0} + {8'd0, key_i[6:0]};

  if (IsPow2) begin : g_mask
    logic             done_q;
    logic [AddrW-1:0] slot_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        slot_q <= hash[AddrW-1:0];
      end
    end

    assign done_o = done_q;
    assign slot_o = slot_q;
  end else begin : g_recip
    // remainder by reciprocal multiplication: capture, quotient, subtract
    localparam int unsigned      Shift  = HashW + AddrW;
    localparam int unsigned      MulW   = HashW + 2;
    localparam int unsigned      ProdW  = HashW + MulW;
    localparam longint unsigned  Recip  = ((64'd1 << Shift) + Slots - 1) / Slots;
    localparam logic [MulW-1:0]  RecipW = MulW'(Recip);
    localparam logic [HashW-1:0] SlotsH = HashW'(Slots);

    logic             s1_q, s2_q, done_q;
    logic [HashW-1:0] h_q;
    logic [HashW-1:0] q_q;
    logic [ProdW-1:0] prod;
    logic [HashW-1:0] qs;
    logic [AddrW-1:0] rem;
    logic [AddrW-1:0] rem_q;

    assign prod = ProdW'(h_q) * ProdW'(RecipW);
    assign qs   = q_q * SlotsH;
    assign rem  = AddrW'(h_q - qs);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        s1_q   <= 1'b0;
        s2_q   <= 1'b0;
        done_q <= 1'b0;
      end else begin
        s1_q   <= start_i;
        s2_q   <= s1_q;
        done_q <= s2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        h_q <= hash;
      end
      if (s1_q) begin
        q_q <= HashW'(prod >> Shift);
      end
      if (s2_q) begin
        rem_q <= rem;
      end
    end

    assign done_o = done_q;
    assign slot_o = rem_q;
  end

endmodule

// ===== design/bank_key_hash_table.sv =====
// Bank key hash table: an open-addressing table with linear probing that holds
// instrument bank keys (7-bit msb, 7-bit lsb, percussion flag; msb 127 forces
// percussion). Opcode 0 looks a key up, opcode 1 looks it up and inserts it into
// the first empty slot if absent. One result word comes back for every input
// word, with hit, slot, inserted, table_full and the occupied count. Slots are
// never removed, and an insert into a full table reports table_full. The table
// lives in a single-port-write, registered-read memory of SLOTS entries. After
// reset a clearing pass writes every slot empty, one slot a cycle, so the block
// takes no input until the pass ends. An operation is accepted, then its home
// slot is computed (by masking the hash when SLOTS is a power of two, by a
// reciprocal-multiply remainder otherwise), then each probed slot takes a memory
// read and a compare, then the result register is loaded. The probe loop through
// the memory read port sets the rate. The input side takes a new word while a
// finished result still waits in the output register.
module bank_key_hash_table #(
  parameter int unsigned SLOTS = kbht_pkg::SlotsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kbht_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kbht_pkg::out_word_t out_word_o
);

  localparam int unsigned AddrW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW   = $clog2(SLOTS + 1);
  localparam int unsigned EntryW = kbht_pkg::EntryW;

  localparam logic [AddrW-1:0] LastSlot  = AddrW'(SLOTS - 1);

  // controller states
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StHash  = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StCmp   = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [AddrW-1:0]  pos_q, pos_d;
  logic [AddrW-1:0]  probes_q, probes_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [EntryW-1:0] key_q, key_d;
  logic              op_q, op_d;
  logic              hit_q, hit_d;
  logic              ins_q, ins_d;
  logic              full_q, full_d;
  logic              out_valid_q, out_valid_d;
  kbht_pkg::out_word_t out_q, out_d;

  logic              in_fire;
  logic              perc;
  logic [AddrW-1:0]  pos_next;

  // memory port
  logic              mem_we;
  logic [EntryW-1:0] mem_wdata;
  logic              mem_re;
  logic [EntryW-1:0] mem_rdata;

  // hash unit
  logic              hash_done;
  logic [AddrW-1:0]  hash_slot;

  // output formatting, widened then cut to the field widths
  logic [31:0]       pos_wide;
  logic [31:0]       cnt_wide;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  assign perc     = in_word_i.percussion || (in_word_i.bank_msb == kbht_pkg::PercMsb);
  assign pos_next = (pos_q == LastSlot) ? '0 : pos_q + AddrW'(1);

  kbht_hash #(
    .Slots (SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .key_i   ({perc, in_word_i.bank_msb, in_word_i.bank_lsb}),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  kbht_mem #(
    .Depth (SLOTS),
    .Width (EntryW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pos_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (mem_rdata)
  );

  assign mem_re = (state_q == StRead);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    probes_d    = probes_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    op_d        = op_q;
    hit_d       = hit_q;
    ins_d       = ins_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_wdata   = key_q;

    pos_wide = 32'(pos_q);
    cnt_wide = 32'(cnt_q);

    // result register drains independently of the probe engine
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StClear: begin
        // clearing pass: empty every slot once after reset
        mem_we    = 1'b1;
        mem_wdata = '0;
        pos_d     = pos_next;
        if (pos_q == LastSlot) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_fire) begin
          key_d   = {1'b1, perc, in_word_i.bank_msb, in_word_i.bank_lsb};
          op_d    = in_word_i.opcode;
          hit_d   = 1'b0;
          ins_d   = 1'b0;
          full_d  = 1'b0;
          state_d = StHash;
        end
      end
      StHash: begin
        if (hash_done) begin
          pos_d    = hash_slot;
          probes_d = '0;
          state_d  = StRead;
        end
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (mem_rdata == key_q) begin
          hit_d   = 1'b1;
          state_d = StDone;
        end else if (!mem_rdata[EntryW-1]) begin
          // empty slot ends the probe; an empty slot means room is left
          if (op_q == kbht_pkg::OpInsert) begin
            mem_we = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
            ins_d  = 1'b1;
          end
          state_d = StDone;
        end else if (probes_q == LastSlot) begin
          // wrapped all the way round without a match or a hole
          full_d  = (op_q == kbht_pkg::OpInsert);
          state_d = StDone;
        end else begin
          pos_d    = pos_next;
          probes_d = probes_q + AddrW'(1);
          state_d  = StRead;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_d.hit              = hit_q;
          out_d.slot_index       = (hit_q || ins_q) ? pos_wide[5:0] : 6'd0;
          out_d.inserted         = ins_q;
          out_d.table_full       = full_q;
          out_d.entry_count      = cnt_wide[6:0];
          state_d                = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      pos_q       <= '0;
      probes_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      probes_q    <= probes_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    op_q   <= op_d;
    hit_q  <= hit_d;
    ins_q  <= ins_d;
    full_q <= full_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NumSlots   = kbht_pkg::SlotsDefault;
  localparam int QuietLimit = 2000;   // full wrap plus the long output hold, with margin
  localparam int HoldCycles = 300;    // long output hold, fills the block up
  localparam int DrainWait  = 300;    // settle time after the last result

  // one pending input word, drain asks the sender to wait for all results first
  typedef struct {
    kbht_pkg::in_word_t word;
    bit                 drain;
  } bank_op_t;

  typedef struct {
    logic [6:0] msb;
    logic [6:0] lsb;
    logic       perc;
  } bank_key_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  kbht_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kbht_pkg::out_word_t out_word;

  bank_op_t            bank_ops_queue[$];     // words still to be offered
  kbht_pkg::out_word_t slot_reports_due[$];   // predicted result words, oldest first

  // shadow copy of the table and its fill level
  logic [15:0] bank_slots[NumSlots];
  int unsigned used_slots = 0;

  int   fail_count = 0;
  int   words_taken = 0;
  int   results_seen = 0;
  int   quiet_cycles = 0;
  bit   in_word_taken = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  logic calm;

  bank_key_t key_pool[48];

  // stretch with no idling on either side
  assign calm = (words_taken >= 120) && (words_taken < 200);

  bank_key_hash_table DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // probe from the home slot, stop on match, empty slot or full wrap,
  // insert on a miss when asked and there is room
  function automatic kbht_pkg::out_word_t probe_and_insert(kbht_pkg::in_word_t w);
    logic                perc;
    logic [15:0]         key;
    int unsigned         pos;
    bit                  found;
    bit                  empty_seen;
    kbht_pkg::out_word_t r;
    perc = w.percussion || (w.bank_msb == kbht_pkg::PercMsb);
    key = {1'b1, perc, w.bank_msb, w.bank_lsb};
    pos = (int'(perc) * 256 + int'(w.bank_msb) * 128 + int'(w.bank_lsb)) % NumSlots;
    found = 1'b0;
    empty_seen = 1'b0;
    for (int n = 0; n < NumSlots; n++) begin
      if (bank_slots[pos] == key) begin
        found = 1'b1;
        break;
      end
      if (!bank_slots[pos][15]) begin
        empty_seen = 1'b1;
        break;
      end
      pos = (pos + 1) % NumSlots;
    end
    r = '0;
    if (found) begin
      r.hit = 1'b1;
      r.slot_index = 6'(pos);
    end else if (w.opcode == kbht_pkg::OpInsert) begin
      if (empty_seen && used_slots < NumSlots) begin
        bank_slots[pos] = key;
        used_slots++;
        r.inserted = 1'b1;
        r.slot_index = 6'(pos);
      end else begin
        r.table_full = 1'b1;
      end
    end
    r.entry_count = 7'(used_slots);
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("result %0d: %s got %0d want %0d", results_seen, what, got, want);
    fail_count++;
  endtask

  task automatic push_op(logic op, logic [6:0] msb, logic [6:0] lsb, logic perc, bit drain);
    bank_op_t item;
    item.word.opcode = op;
    item.word.bank_msb = msb;
    item.word.bank_lsb = lsb;
    item.word.percussion = perc;
    item.drain = drain;
    bank_ops_queue.push_back(item);
  endtask

  function automatic bank_key_t any_key();
    bank_key_t k;
    k.msb = 7'($urandom_range(127));
    k.lsb = 7'($urandom_range(127));
    k.perc = 1'($urandom_range(1));
    return k;
  endfunction

  // input driver, changes at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_word_taken) begin
        // a drain word waits for every outstanding result
        if (bank_ops_queue.size() != 0 &&
            !(bank_ops_queue[0].drain && slot_reports_due.size() != 0) &&
            (calm || $urandom_range(99) >= 6)) begin
          in_word <= bank_ops_queue[0].word;
          in_valid <= 1'b1;
          void'(bank_ops_queue.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
        in_word_taken = 1'b0;
      end
    end
  end

  // output ready, one long hold early on while the sender keeps going
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = HoldCycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // monitor, samples both handshakes at the rising edge
  always @(posedge clk) begin
    kbht_pkg::out_word_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (out_valid && out_ready) begin
        quiet_cycles = 0;
        if (slot_reports_due.size() == 0) begin
          flag_mismatch("word with nothing expected", 1, 0);
        end else begin
          want = slot_reports_due.pop_front();
          if (out_word.hit !== want.hit)
            flag_mismatch("hit", out_word.hit, want.hit);
          if (out_word.slot_index !== want.slot_index)
            flag_mismatch("slot_index", out_word.slot_index, want.slot_index);
          if (out_word.inserted !== want.inserted)
            flag_mismatch("inserted", out_word.inserted, want.inserted);
          if (out_word.table_full !== want.table_full)
            flag_mismatch("table_full", out_word.table_full, want.table_full);
          if (out_word.entry_count !== want.entry_count)
            flag_mismatch("entry_count", out_word.entry_count, want.entry_count);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        quiet_cycles = 0;
        slot_reports_due.push_back(probe_and_insert(in_word));
        in_word_taken = 1'b1;
        words_taken++;
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    bank_key_t k;
    for (int i = 0; i < NumSlots; i++) bank_slots[i] = '0;

    // about half the pool crowds onto the first few home slots
    for (int i = 0; i < 48; i++) begin
      key_pool[i] = any_key();
      if (i % 2 == 1) key_pool[i].lsb[5:0] = 6'($urandom_range(3));
    end

    // directed part
    push_op(kbht_pkg::OpLookup, 7'd0,   7'd0,   1'b0, 1'b0);  // miss on the empty table
    push_op(kbht_pkg::OpInsert, 7'd0,   7'd0,   1'b0, 1'b0);  // insert at slot 0
    push_op(kbht_pkg::OpInsert, 7'd0,   7'd0,   1'b0, 1'b0);  // hit with insert, no write
    push_op(kbht_pkg::OpLookup, 7'd0,   7'd0,   1'b0, 1'b0);  // plain hit
    push_op(kbht_pkg::OpInsert, 7'd127, 7'd127, 1'b0, 1'b0);  // msb 127 forces percussion
    push_op(kbht_pkg::OpLookup, 7'd127, 7'd127, 1'b1, 1'b0);  // same key with flag given
    push_op(kbht_pkg::OpInsert, 7'd0,   7'd64,  1'b0, 1'b0);  // collides at home slot 0
    push_op(kbht_pkg::OpInsert, 7'd1,   7'd0,   1'b1, 1'b0);  // longer chain from slot 0
    push_op(kbht_pkg::OpInsert, 7'd0,   7'd0,   1'b1, 1'b0);  // differs only in percussion
    push_op(kbht_pkg::OpInsert, 7'd0,   7'd127, 1'b0, 1'b0);  // home slot 63 taken, wraps
    push_op(kbht_pkg::OpLookup, 7'd0,   7'd127, 1'b0, 1'b0);  // hit found after the wrap
    push_op(kbht_pkg::OpLookup, 7'd5,   7'd0,   1'b0, 1'b0);  // miss at end of a chain
    push_op(kbht_pkg::OpInsert, 7'd127, 7'd0,   1'b0, 1'b0);
    push_op(kbht_pkg::OpInsert, 7'd127, 7'd0,   1'b1, 1'b0);  // same key, hit
    push_op(kbht_pkg::OpLookup, 7'd127, 7'd127, 1'b0, 1'b0);
    push_op(kbht_pkg::OpInsert, 7'd85,  7'd42,  1'b1, 1'b0);
    push_op(kbht_pkg::OpLookup, 7'd42,  7'd85,  1'b0, 1'b0);

    // mixed traffic while the table fills
    for (int i = 0; i < 260; i++) begin
      k = ($urandom_range(99) < 65) ? key_pool[$urandom_range(47)] : any_key();
      push_op(($urandom_range(99) < 35) ? kbht_pkg::OpInsert : kbht_pkg::OpLookup,
              k.msb, k.lsb, k.perc, 1'b0);
    end

    // seventy distinct keys are more than the table holds, so it ends up full
    for (int i = 0; i < 70; i++)
      push_op(kbht_pkg::OpInsert, 7'(i), 7'd85, 1'b1, i == 0);

    // full table: hits, full-wrap misses and rejected inserts
    for (int i = 0; i < 250; i++) begin
      if ($urandom_range(99) < 50) begin
        k = key_pool[$urandom_range(47)];
      end else if ($urandom_range(99) < 40) begin
        k.msb = 7'($urandom_range(69));
        k.lsb = 7'd85;
        k.perc = 1'b1;
      end else begin
        k = any_key();
      end
      push_op(($urandom_range(1) == 1) ? kbht_pkg::OpInsert : kbht_pkg::OpLookup,
              k.msb, k.lsb, k.perc, i == 0);
    end

    // reset, released at a falling edge
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (bank_ops_queue.size() != 0 || in_valid) @(posedge clk);
    while (slot_reports_due.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (fail_count == 0 && slot_reports_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/kbht_pkg.sv
design/kbht_mem.sv
design/kbht_hash.sv
design/bank_key_hash_table.sv
test/testbench.sv
